// ----- hdl/flcs_pkg.sv -----
`default_nettype none
package flcs_pkg;

	localparam int unsigned PitchLimitDefault = 15646;
	localparam int unsigned CordicSteps = 16;
	localparam logic signed [33:0] CordicGain = 34'sd652032874;
	localparam logic signed [31:0] PosYReset = 32'sd111411;
	localparam logic [15:0] InvSqrt2 = 16'd46341;
	localparam logic [23:0] MoveSpeedReset = 24'd327680;
	localparam logic [15:0] LookSensReset = 16'd8010;

	// register indexes
	localparam logic [0:0] REG_MOVE_SPEED = 1'b0;
	localparam logic [0:0] REG_LOOK_SENS = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_TURN,
		ST_CORDIC_YAW,
		ST_CORDIC_PITCH,
		ST_STEP,
		ST_DIAG,
		ST_MOVE_A,
		ST_MOVE_B,
		ST_MOVE_C,
		ST_MOVE_D,
		ST_LOOK_A,
		ST_LOOK_B,
		ST_DONE
	} flcs_state_t;

	typedef struct packed {
		logic load;
		logic turn;
		logic cordic_start_yaw;
		logic cordic_start_pitch;
		logic step;
		logic diag;
		logic move_a;
		logic move_b;
		logic move_c;
		logic move_d;
		logic look_a;
		logic look_b;
		logic publish;
	} flcs_cmd_t;

	typedef struct packed {
		logic cordic_busy;
		logic moving;
		logic diagonal;
	} flcs_status_t;

	function automatic logic [31:0] atan_entry(input logic [3:0] i);
		logic [31:0] r;
		begin
			unique case (i)
				4'd0: r = 32'h20000000;
				4'd1: r = 32'h12E4051E;
				4'd2: r = 32'h09FB385B;
				4'd3: r = 32'h051111D4;
				4'd4: r = 32'h028B0D43;
				4'd5: r = 32'h0145D7E1;
				4'd6: r = 32'h00A2F61E;
				4'd7: r = 32'h00517C55;
				4'd8: r = 32'h0028BE53;
				4'd9: r = 32'h00145F2F;
				4'd10: r = 32'h000A2F98;
				4'd11: r = 32'h000517CC;
				4'd12: r = 32'h00028BE6;
				4'd13: r = 32'h000145F3;
				4'd14: r = 32'h0000A2FA;
				default: r = 32'h0000517D;
			endcase
			return r;
		end
	endfunction

	// saturate a 34-bit sum to signed 32 bits
	function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
		logic signed [31:0] r;
		begin
			if (v > 34'sd2147483647) r = 32'sh7FFFFFFF;
			else if (v < -34'sd2147483648) r = 32'sh80000000;
			else r = v[31:0];
			return r;
		end
	endfunction

endpackage
`default_nettype wire

// ----- hdl/flcs_if.sv -----
`default_nettype none
interface flcs_in_if;
	logic valid;
	logic ready;
	logic signed [15:0] mouse_dx;
	logic signed [15:0] mouse_dy;
	logic go_forward;
	logic go_backward;
	logic go_right;
	logic go_left;
	logic [15:0] frame_time;
	modport source (output valid, mouse_dx, mouse_dy, go_forward, go_backward, go_right,
		go_left, frame_time, input ready);
	modport sink (input valid, mouse_dx, mouse_dy, go_forward, go_backward, go_right,
		go_left, frame_time, output ready);
endinterface

interface flcs_out_if;
	logic valid;
	logic ready;
	logic signed [31:0] eye_x;
	logic signed [31:0] eye_y;
	logic signed [31:0] eye_z;
	logic signed [31:0] look_x;
	logic signed [31:0] look_y;
	logic signed [31:0] look_z;
	modport source (output valid, eye_x, eye_y, eye_z, look_x, look_y, look_z, input ready);
	modport sink (input valid, eye_x, eye_y, eye_z, look_x, look_y, look_z, output ready);
endinterface

interface flcs_cfg_if;
	logic valid;
	logic ready;
	logic [0:0] index;
	logic [23:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- hdl/flcs_cordic.sv -----
`default_nettype none
module flcs_cordic import flcs_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [15:0] angle,
	output logic busy,
	output logic signed [31:0] sin_q,
	output logic signed [31:0] cos_q
);

	logic signed [33:0] x_q, y_q;
	logic signed [32:0] z_q;
	logic flip_q;
	logic [3:0] iter_q;
	logic run_q;
	logic [31:0] a_full;
	logic flip_in;
	logic [31:0] a_rot;
	logic signed [33:0] dx, dy;
	logic signed [32:0] at;
	logic signed [33:0] xr, yr;

	assign a_full = {angle, 16'h0000};
	assign flip_in = (a_full >= 32'h40000000) && (a_full < 32'hC0000000);
	assign a_rot = flip_in ? a_full + 32'h80000000 : a_full;
	assign dx = y_q >>> iter_q;
	assign dy = x_q >>> iter_q;
	assign at = {1'b0, atan_entry(iter_q)};
	assign busy = run_q;
	assign xr = (x_q + 34'sd8192) >>> 14;
	assign yr = (y_q + 34'sd8192) >>> 14;

	// one micro-rotation per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			iter_q <= '0;
		end else if (start) begin
			run_q <= 1'b1;
			iter_q <= '0;
		end else if (run_q) begin
			iter_q <= iter_q + 4'd1;
			if (iter_q == 4'(CordicSteps - 1)) run_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= CordicGain;
			y_q <= '0;
			z_q <= {a_rot[31], a_rot};
			flip_q <= flip_in;
		end else if (run_q) begin
			if (!z_q[32]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + at;
			end
		end
	end

	// round to Q16.16 and undo the half-turn fold
	assign cos_q = flip_q ? -xr[31:0] : xr[31:0];
	assign sin_q = flip_q ? -yr[31:0] : yr[31:0];

endmodule
`default_nettype wire

// ----- hdl/flcs_datapath.sv -----
`default_nettype none
module flcs_datapath import flcs_pkg::*; #(
	parameter int unsigned PITCH_LIMIT = PitchLimitDefault
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire flcs_cmd_t cmd,
	output flcs_status_t status,
	flcs_in_if.sink in_ch,
	flcs_cfg_if.sink cfg_ch,
	input wire logic cfg_write,
	output logic signed [31:0] eye_x_q,
	output logic signed [31:0] eye_y_q,
	output logic signed [31:0] eye_z_q,
	output logic signed [31:0] look_x_q,
	output logic signed [31:0] look_y_q,
	output logic signed [31:0] look_z_q
);

	localparam logic signed [17:0] PLim = 18'(PITCH_LIMIT);

	logic [23:0] move_speed_q;
	logic [15:0] look_sens_q;
	logic signed [31:0] pos_x_q, pos_y_q, pos_z_q;
	logic [15:0] yaw_q;
	logic signed [15:0] pitch_q;
	logic signed [15:0] mdx_q, mdy_q;
	logic [1:0] fwd_q, side_q;
	logic [15:0] ft_q;
	logic signed [31:0] sy_q, cy_q, sp_q, cp_q;
	logic signed [31:0] step_q;
	logic signed [33:0] accx_q, accz_q;
	logic signed [31:0] fs_q, rs_q;
	logic cordic_start;
	logic [15:0] cordic_angle;
	logic signed [31:0] c_sin, c_cos;
	logic signed [32:0] tx_p, ty_p;
	logic signed [15:0] turn_x;
	logic signed [33:0] pitch_wide;
	logic signed [31:0] ma_a, ma_b;
	logic signed [63:0] mprod;
	logic signed [31:0] mres;
	logic signed [31:0] fwd_s, side_s;
	logic [39:0] step_prod;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			move_speed_q <= MoveSpeedReset;
			look_sens_q <= LookSensReset;
		end else if (cfg_write) begin
			unique case (cfg_ch.index)
				REG_MOVE_SPEED: move_speed_q <= cfg_ch.data;
				REG_LOOK_SENS: look_sens_q <= cfg_ch.data[15:0];
				default: ;
			endcase
		end
	end

	// shared cordic
	assign cordic_start = cmd.cordic_start_yaw | cmd.cordic_start_pitch;
	assign cordic_angle = cmd.cordic_start_yaw ? yaw_q : pitch_q;
	flcs_cordic u_cordic (
		.clk(clk), .arst_n(arst_n), .start(cordic_start), .angle(cordic_angle),
		.busy(status.cordic_busy), .sin_q(c_sin), .cos_q(c_cos)
	);

	// mouse turn
	assign tx_p = (mdx_q * $signed({1'b0, look_sens_q}) + 33'sd128) >>> 8;
	assign ty_p = (mdy_q * $signed({1'b0, look_sens_q}) + 33'sd128) >>> 8;
	assign turn_x = tx_p[15:0];
	assign pitch_wide = 34'(pitch_q) - 34'(ty_p);

	// shared Q16.16 multiplier
	always_comb begin
		ma_a = fs_q;
		ma_b = sy_q;
		priority case (1'b1)
			cmd.move_a: begin ma_a = fwd_s; ma_b = sy_q; end
			cmd.move_b: begin ma_a = rs_q; ma_b = -cy_q; end
			cmd.move_c: begin ma_a = fs_q; ma_b = cy_q; end
			cmd.move_d: begin ma_a = rs_q; ma_b = sy_q; end
			cmd.look_a: begin ma_a = sy_q; ma_b = cp_q; end
			cmd.look_b: begin ma_a = cy_q; ma_b = cp_q; end
			cmd.diag: begin ma_a = step_q; ma_b = 32'(InvSqrt2); end
			default: ;
		endcase
	end
	assign mprod = ma_a * ma_b + 64'sd32768;
	assign mres = mprod[47:16];
	assign step_prod = move_speed_q * ft_q + 40'd32768;

	assign fwd_s = (fwd_q == 2'b01) ? step_q : (fwd_q == 2'b11) ? -step_q : '0;
	assign side_s = (side_q == 2'b01) ? step_q : (side_q == 2'b11) ? -step_q : '0;

	assign status.moving = (fwd_q != 2'b00) || (side_q != 2'b00);
	assign status.diagonal = (fwd_q != 2'b00) && (side_q != 2'b00);
	assign in_ch.ready = cmd.load;
	assign cfg_ch.ready = 1'b1;

	// camera state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q <= '0;
			pos_y_q <= PosYReset;
			pos_z_q <= '0;
			yaw_q <= '0;
			pitch_q <= '0;
		end else begin
			if (cmd.turn) begin
				yaw_q <= yaw_q - turn_x;
				if (pitch_wide > PLim) pitch_q <= PLim[15:0];
				else if (pitch_wide < -PLim) pitch_q <= 16'(-PLim);
				else pitch_q <= pitch_wide[15:0];
			end
			if (cmd.move_d) begin
				pos_x_q <= sat32(accx_q);
				pos_z_q <= sat32(accz_q + 34'(mres));
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.load && in_ch.valid) begin
			mdx_q <= in_ch.mouse_dx;
			mdy_q <= in_ch.mouse_dy;
			fwd_q <= 2'(in_ch.go_forward) - 2'(in_ch.go_backward);
			side_q <= 2'(in_ch.go_right) - 2'(in_ch.go_left);
			ft_q <= in_ch.frame_time;
		end
		if (cmd.cordic_start_pitch) begin
			sy_q <= c_sin;
			cy_q <= c_cos;
		end
		if (cmd.step) begin
			sp_q <= c_sin;
			cp_q <= c_cos;
			step_q <= {8'd0, step_prod[39:16]};
		end
		if (cmd.diag) step_q <= mres;
		if (cmd.move_a) begin
			fs_q <= fwd_s;
			rs_q <= side_s;
		end
		// x takes its two products first, then z
		if (cmd.move_a) accx_q <= 34'(pos_x_q) + 34'(mres);
		if (cmd.move_b) accx_q <= accx_q + 34'(mres);
		if (cmd.move_c) accz_q <= 34'(pos_z_q) + 34'(mres);
		if (cmd.look_a) look_x_q <= sat32(34'(pos_x_q) + 34'(mres));
		if (cmd.look_b) begin
			look_z_q <= sat32(34'(pos_z_q) + 34'(mres));
			look_y_q <= sat32(34'(pos_y_q) + 34'(sp_q));
			eye_x_q <= pos_x_q;
			eye_y_q <= pos_y_q;
			eye_z_q <= pos_z_q;
		end
	end

endmodule
`default_nettype wire

// ----- hdl/flcs_ctrl.sv -----
`default_nettype none
module flcs_ctrl import flcs_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic out_ready,
	input wire flcs_status_t status,
	output flcs_cmd_t cmd,
	output logic out_valid
);

	flcs_state_t state_q, state_d;
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.publish) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end
	assign out_valid = out_valid_q;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.load = 1'b1;
				if (in_valid) state_d = ST_TURN;
			end
			ST_TURN: begin
				cmd.turn = 1'b1;
				state_d = ST_CORDIC_YAW;
			end
			ST_CORDIC_YAW: begin
				cmd.cordic_start_yaw = 1'b1;
				state_d = ST_CORDIC_PITCH;
			end
			ST_CORDIC_PITCH: begin
				if (!status.cordic_busy) begin
					cmd.cordic_start_pitch = 1'b1;
					state_d = ST_STEP;
				end
			end
			ST_STEP: begin
				if (!status.cordic_busy) begin
					cmd.step = 1'b1;
					state_d = status.diagonal ? ST_DIAG : ST_MOVE_A;
				end
			end
			ST_DIAG: begin
				cmd.diag = 1'b1;
				state_d = ST_MOVE_A;
			end
			ST_MOVE_A: begin
				cmd.move_a = 1'b1;
				state_d = status.moving ? ST_MOVE_B : ST_LOOK_A;
			end
			ST_MOVE_B: begin
				cmd.move_b = 1'b1;
				state_d = ST_MOVE_C;
			end
			ST_MOVE_C: begin
				cmd.move_c = 1'b1;
				state_d = ST_MOVE_D;
			end
			ST_MOVE_D: begin
				cmd.move_d = 1'b1;
				state_d = ST_LOOK_A;
			end
			ST_LOOK_A: begin
				cmd.look_a = 1'b1;
				state_d = ST_LOOK_B;
			end
			ST_LOOK_B: begin
				cmd.look_b = 1'b1;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				// wait for the result register to free up
				if (!out_valid_q || out_ready) begin
					cmd.publish = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule
`default_nettype wire

// ----- hdl/free_look_camera_step_unit.sv -----
// Free-look camera step: one result request per input request.
// Most of the time from input accept to result valid is set by two 16-step CORDIC
// runs on a shared rotator, yaw then pitch; a straight move adds the move states,
// and a diagonal move also adds a diagonal scaling step.
// One item at a time: a new input is taken only after the last result is published.
// Reset: position (0, 1.7, 0), yaw and pitch zero, registers to defaults.
`default_nettype none
module free_look_camera_step_unit import flcs_pkg::*; #(
	parameter int unsigned PITCH_LIMIT = PitchLimitDefault
) (
	input wire logic clk,
	input wire logic arst_n,
	flcs_in_if.sink in_ch,
	flcs_out_if.source out_ch,
	flcs_cfg_if.sink cfg_ch
);

	flcs_cmd_t cmd;
	flcs_status_t status;
	logic signed [31:0] eye_x, eye_y, eye_z, look_x, look_y, look_z;

	flcs_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid), .out_ready(out_ch.ready),
		.status(status), .cmd(cmd), .out_valid(out_ch.valid)
	);

	flcs_datapath #(.PITCH_LIMIT(PITCH_LIMIT)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .status(status), .in_ch(in_ch),
		.cfg_ch(cfg_ch), .cfg_write(cfg_ch.valid),
		.eye_x_q(eye_x), .eye_y_q(eye_y), .eye_z_q(eye_z),
		.look_x_q(look_x), .look_y_q(look_y), .look_z_q(look_z)
	);

	// result register holds after publish
	always_ff @(posedge clk) begin
		if (cmd.publish) begin
			out_ch.eye_x <= eye_x;
			out_ch.eye_y <= eye_y;
			out_ch.eye_z <= eye_z;
			out_ch.look_x <= look_x;
			out_ch.look_y <= look_y;
			out_ch.look_z <= look_z;
		end
	end

endmodule
`default_nettype wire
